// ===== sv/asra_pkg.sv =====
// Package for the adaptive sampling-range adjuster: widths, constants, codes,
// controller states and the command and status bundles.
// No dependencies; used by asra_ctrl, asra_datapath and the top level.
`default_nettype none

package asra_pkg;

   // Largest sampling range; the range lives in 1..BASE.
   localparam int BASE         = 16384;
   localparam int RANGE_W      = 15;

   localparam int EXPECTED_W   = 20;
   localparam int EXPECTED_RST = 1000;
   localparam int COUNT_W      = 32;
   localparam int IV_W         = 32;
   localparam int TIME_W       = 48;

   localparam int USEC_PER_SEC = 1000000;
   localparam int USEC_W       = 20;

   // Datapath widths.
   localparam int PROD_W       = EXPECTED_W + RANGE_W;   // expected * scale
   localparam int ACC_W        = PROD_W + TIME_W;         // full numerator
   localparam int D_W          = USEC_W + COUNT_W;        // divisor
   localparam int Q_W          = PROD_W;                  // kept quotient bits
   localparam int CHUNK_BITS   = 16;
   localparam int MUL_CHUNKS   = TIME_W / CHUNK_BITS;
   localparam int CHUNK_W      = 2;
   localparam int STEP_W       = 6;
   localparam int BLEND_W      = Q_W + USEC_W + 1;

   // Any quotient at or above this value clamps to BASE, blended or not.
   localparam logic [Q_W-1:0] Q_CAP =
      Q_W'((64'(BASE) + 64'd1) * 64'(USEC_PER_SEC));

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_ROUND  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_STEP,
      ST_BLEND_MUL,
      ST_COMMIT
   } asra_state_type;

   typedef struct packed {
      logic               load;
      logic               prep;
      logic               mul_step;
      logic [CHUNK_W-1:0] mul_chunk;
      logic               div_start;
      logic               div_step;
      logic               blend_pass;
      logic               blend_mul;
      logic               commit;
   } asra_cmd_type;

   typedef struct packed {
      logic needs_compute;
      logic blend;
   } asra_status_type;

endpackage

`default_nettype wire

// ===== sv/asra_ctrl.sv =====
// Controller for the sampling-range adjuster: sequences load, multiply,
// divide, blend and commit, and owns both handshakes. Depends on asra_pkg.
`default_nettype none

module asra_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire asra_pkg::asra_status_type status,
   output asra_pkg::asra_cmd_type      cmd
);

   asra_pkg::asra_state_type             state_ff, state_in;
   logic [asra_pkg::STEP_W-1:0]          step_ff, step_in;
   logic                                 pass_ff, pass_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asra_pkg::ST_IDLE;
         step_ff      <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != asra_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      pass_in        = pass_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd            = '0;
      cmd.blend_pass = pass_ff;
      cmd.mul_chunk  = step_ff[asra_pkg::CHUNK_W-1:0];
      unique case (state_ff)
         asra_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = asra_pkg::ST_EVAL;
            end
         end
         asra_pkg::ST_EVAL: begin
            step_in = '0;
            pass_in = 1'b0;
            if (status.needs_compute) begin
               cmd.prep = 1'b1;
               state_in = asra_pkg::ST_MUL;
            end else begin
               state_in = asra_pkg::ST_COMMIT;
            end
         end
         asra_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (step_ff == asra_pkg::STEP_W'(asra_pkg::MUL_CHUNKS - 1)) begin
               step_in  = '0;
               state_in = asra_pkg::ST_DIV_START;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         asra_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
            step_in       = '0;
            state_in      = asra_pkg::ST_DIV_STEP;
         end
         asra_pkg::ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (step_ff == asra_pkg::STEP_W'(asra_pkg::Q_W - 1)) begin
               step_in = '0;
               if (!pass_ff && status.blend) begin
                  state_in = asra_pkg::ST_BLEND_MUL;
               end else begin
                  state_in = asra_pkg::ST_COMMIT;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         asra_pkg::ST_BLEND_MUL: begin
            cmd.blend_mul = 1'b1;
            pass_in       = 1'b1;
            state_in      = asra_pkg::ST_DIV_START;
         end
         asra_pkg::ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               pass_in      = 1'b0;
               state_in     = asra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = asra_pkg::ST_IDLE;
         end
      endcase
   end

   // The step counter never runs past the last divide step.
   assert property (@(posedge clock) disable iff (reset)
      step_ff <= asra_pkg::STEP_W'(asra_pkg::Q_W - 1))
      else $error("step counter out of range");

   // A commit is only issued when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit while output register is occupied");

   // The blend pass is only active in the divide phase or at commit.
   assert property (@(posedge clock) disable iff (reset)
      pass_ff |-> (state_ff == asra_pkg::ST_DIV_START || state_ff == asra_pkg::ST_DIV_STEP
                   || state_ff == asra_pkg::ST_COMMIT))
      else $error("blend pass flag set outside divide or commit");

endmodule

`default_nettype wire

// ===== sv/asra_datapath.sv =====
// Datapath for the sampling-range adjuster: sampler state, the expected-rate
// register, a chunked multiplier, a restoring divider and the output register.
// Depends on asra_pkg; driven by asra_ctrl through command and status bundles.
`default_nettype none

module asra_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [asra_pkg::EXPECTED_W-1:0]      csr_write_data,
   input  wire logic                                 req_operation,
   input  wire logic [asra_pkg::COUNT_W-1:0]         req_round_count,
   input  wire logic signed [asra_pkg::IV_W-1:0]     req_interval_us,
   input  wire logic [asra_pkg::TIME_W-1:0]          req_now_us,
   input  wire asra_pkg::asra_cmd_type               cmd,
   output asra_pkg::asra_status_type                 status,
   output logic [asra_pkg::RANGE_W-1:0]              rsp_sampling_range,
   output logic                                      rsp_wake_request,
   output logic                                      rsp_range_changed
);

   // Sampler state and configuration.
   logic [asra_pkg::EXPECTED_W-1:0] expected_ff, expected_in;
   logic [asra_pkg::RANGE_W-1:0]    range_ff, range_in;
   logic                            grabbed_ff, grabbed_in;
   logic [asra_pkg::COUNT_W-1:0]    prev_count_ff, prev_count_in;
   logic [asra_pkg::TIME_W-1:0]     first_time_ff, first_time_in;
   logic [asra_pkg::COUNT_W-1:0]    early_ff, early_in;

   // Latched item.
   logic                            op_ff, op_in;
   logic [asra_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic signed [asra_pkg::IV_W-1:0] iv_ff, iv_in;
   logic [asra_pkg::TIME_W-1:0]     now_ff, now_in;

   // Arithmetic registers.
   logic [asra_pkg::TIME_W-1:0]     interval_ff, interval_in;
   logic [asra_pkg::PROD_W-1:0]     es_prod_ff, es_prod_in;
   logic [asra_pkg::D_W-1:0]        div_d_ff, div_d_in;
   logic                            blend_ff, blend_in;
   logic [asra_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic [asra_pkg::D_W-1:0]        rem_ff, rem_in;
   logic [asra_pkg::Q_W-1:0]        low_ff, low_in;
   logic [asra_pkg::Q_W-1:0]        q_ff, q_in;
   logic                            sat_ff, sat_in;
   logic [asra_pkg::Q_W+asra_pkg::USEC_W-1:0] p1_ff, p1_in;
   logic [asra_pkg::PROD_W-1:0]     p2_ff, p2_in;

   // Output register.
   logic [asra_pkg::RANGE_W-1:0]    out_range_ff, out_range_in;
   logic                            out_wake_ff, out_wake_in;
   logic                            out_changed_ff, out_changed_in;

   // Combinational intermediates.
   logic [asra_pkg::COUNT_W-1:0]    delta;
   logic [asra_pkg::TIME_W-1:0]     interval_sel;
   logic [asra_pkg::RANGE_W-1:0]    scale;
   logic [asra_pkg::CHUNK_BITS-1:0] chunk_sel;
   logic [asra_pkg::PROD_W+asra_pkg::CHUNK_BITS-1:0] part_prod;
   logic [asra_pkg::BLEND_W-1:0]    blend_sum;
   logic [asra_pkg::ACC_W-1:0]      div_num;
   logic [asra_pkg::D_W-1:0]        div_d;
   logic [asra_pkg::ACC_W-asra_pkg::Q_W-1:0] div_top;
   logic [asra_pkg::D_W:0]          trial;
   logic [asra_pkg::Q_W-1:0]        q_cap;
   logic [asra_pkg::USEC_W-1:0]     iv_short;
   logic [asra_pkg::USEC_W-1:0]     iv_rest;
   logic [asra_pkg::RANGE_W-1:0]    new_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= asra_pkg::EXPECTED_W'(asra_pkg::EXPECTED_RST);
         range_ff      <= asra_pkg::RANGE_W'(asra_pkg::BASE);
         grabbed_ff    <= 1'b0;
         prev_count_ff <= '0;
         first_time_ff <= '0;
         early_ff      <= '0;
      end else begin
         expected_ff   <= expected_in;
         range_ff      <= range_in;
         grabbed_ff    <= grabbed_in;
         prev_count_ff <= prev_count_in;
         first_time_ff <= first_time_in;
         early_ff      <= early_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      count_ff       <= count_in;
      iv_ff          <= iv_in;
      now_ff         <= now_in;
      interval_ff    <= interval_in;
      es_prod_ff     <= es_prod_in;
      div_d_ff       <= div_d_in;
      blend_ff       <= blend_in;
      acc_ff         <= acc_in;
      rem_ff         <= rem_in;
      low_ff         <= low_in;
      q_ff           <= q_in;
      sat_ff         <= sat_in;
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      out_range_ff   <= out_range_in;
      out_wake_ff    <= out_wake_in;
      out_changed_ff <= out_changed_in;
   end

   assign delta = count_ff - prev_count_ff;

   assign status.needs_compute = (op_ff == asra_pkg::OP_ROUND) && (delta != '0);
   assign status.blend         = blend_ff;

   // Interval for this round: negative counts as zero; a first round after
   // submissions uses the time since the first sample instead.
   always_comb begin
      interval_sel = iv_ff[asra_pkg::IV_W-1] ? '0
                     : asra_pkg::TIME_W'(iv_ff[asra_pkg::IV_W-2:0]);
      if (!grabbed_ff && (early_ff != '0)) begin
         interval_sel = (now_ff >= first_time_ff) ? (now_ff - first_time_ff) : '0;
      end
      scale = grabbed_ff ? range_ff : asra_pkg::RANGE_W'(asra_pkg::BASE);
   end

   assign chunk_sel = asra_pkg::CHUNK_BITS'(interval_ff >> (asra_pkg::CHUNK_BITS *
                      (asra_pkg::MUL_CHUNKS - 1 - int'(cmd.mul_chunk))));
   assign part_prod = (asra_pkg::PROD_W + asra_pkg::CHUNK_BITS)'(es_prod_ff) *
                      (asra_pkg::PROD_W + asra_pkg::CHUNK_BITS)'(chunk_sel);

   // The divider is shared by the rescale and the blend.
   assign q_cap     = (sat_ff || (q_ff > asra_pkg::Q_CAP)) ? asra_pkg::Q_CAP : q_ff;
   assign iv_short  = interval_ff[asra_pkg::USEC_W-1:0];
   assign iv_rest   = asra_pkg::USEC_W'(asra_pkg::USEC_PER_SEC) - iv_short;
   assign blend_sum = asra_pkg::BLEND_W'(p1_ff) + asra_pkg::BLEND_W'(p2_ff);
   assign div_num   = cmd.blend_pass ? asra_pkg::ACC_W'(blend_sum) : acc_ff;
   assign div_d     = cmd.blend_pass ? asra_pkg::D_W'(asra_pkg::USEC_PER_SEC) : div_d_ff;
   assign div_top   = div_num[asra_pkg::ACC_W-1:asra_pkg::Q_W];
   assign trial     = {rem_ff, low_ff[asra_pkg::Q_W-1]};

   always_comb begin
      if (q_cap == '0) begin
         new_range = asra_pkg::RANGE_W'(1);
      end else if (q_cap > asra_pkg::Q_W'(asra_pkg::BASE)) begin
         new_range = asra_pkg::RANGE_W'(asra_pkg::BASE);
      end else begin
         new_range = q_cap[asra_pkg::RANGE_W-1:0];
      end
   end

   always_comb begin
      expected_in    = csr_write_enable ? csr_write_data : expected_ff;
      range_in       = range_ff;
      grabbed_in     = grabbed_ff;
      prev_count_in  = prev_count_ff;
      first_time_in  = first_time_ff;
      early_in       = early_ff;
      op_in          = op_ff;
      count_in       = count_ff;
      iv_in          = iv_ff;
      now_in         = now_ff;
      interval_in    = interval_ff;
      es_prod_in     = es_prod_ff;
      div_d_in       = div_d_ff;
      blend_in       = blend_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      low_in         = low_ff;
      q_in           = q_ff;
      sat_in         = sat_ff;
      p1_in          = p1_ff;
      p2_in          = p2_ff;
      out_range_in   = out_range_ff;
      out_wake_in    = out_wake_ff;
      out_changed_in = out_changed_ff;

      if (cmd.load) begin
         op_in    = req_operation;
         count_in = req_round_count;
         iv_in    = req_interval_us;
         now_in   = req_now_us;
      end

      if (cmd.prep) begin
         interval_in = interval_sel;
         es_prod_in  = asra_pkg::PROD_W'(expected_ff) * asra_pkg::PROD_W'(scale);
         div_d_in    = asra_pkg::D_W'(asra_pkg::USEC_PER_SEC) * asra_pkg::D_W'(delta);
         blend_in    = grabbed_ff &&
                       (interval_sel < asra_pkg::TIME_W'(asra_pkg::USEC_PER_SEC));
         acc_in      = '0;
      end

      if (cmd.mul_step) begin
         acc_in = (acc_ff << asra_pkg::CHUNK_BITS) + asra_pkg::ACC_W'(part_prod);
      end

      if (cmd.div_start) begin
         sat_in = (asra_pkg::D_W'(div_top) >= div_d);
         rem_in = sat_in ? '0 : asra_pkg::D_W'(div_top);
         low_in = div_num[asra_pkg::Q_W-1:0];
         q_in   = '0;
      end

      if (cmd.div_step) begin
         low_in = {low_ff[asra_pkg::Q_W-2:0], 1'b0};
         if (trial >= {1'b0, div_d}) begin
            rem_in = asra_pkg::D_W'(trial - {1'b0, div_d});
            q_in   = {q_ff[asra_pkg::Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[asra_pkg::D_W-1:0];
            q_in   = {q_ff[asra_pkg::Q_W-2:0], 1'b0};
         end
      end

      if (cmd.blend_mul) begin
         p1_in = (asra_pkg::Q_W + asra_pkg::USEC_W)'(q_cap) *
                 (asra_pkg::Q_W + asra_pkg::USEC_W)'(iv_short);
         p2_in = asra_pkg::PROD_W'(range_ff) * asra_pkg::PROD_W'(iv_rest);
      end

      if (cmd.commit) begin
         out_range_in   = range_ff;
         out_wake_in    = 1'b0;
         out_changed_in = 1'b0;
         if (op_ff == asra_pkg::OP_SUBMIT) begin
            if (!grabbed_ff) begin
               if (early_ff != '1) begin
                  early_in = early_ff + 1'b1;
               end
               if (early_ff == '0) begin
                  first_time_in = now_ff;
               end else if (early_ff >= asra_pkg::COUNT_W'(expected_ff)) begin
                  out_wake_in = 1'b1;
               end
            end
         end else if (delta != '0) begin
            prev_count_in = count_ff;
            grabbed_in    = 1'b1;
            out_range_in  = new_range;
            if (new_range != range_ff) begin
               range_in       = new_range;
               out_changed_in = 1'b1;
            end
         end
      end
   end

   assign rsp_sampling_range = out_range_ff;
   assign rsp_wake_request   = out_wake_ff;
   assign rsp_range_changed  = out_changed_ff;

   // The held range always stays inside 1..BASE.
   assert property (@(posedge clock) disable iff (reset)
      (range_ff != '0) && (range_ff <= asra_pkg::RANGE_W'(asra_pkg::BASE)))
      else $error("sampling range left 1..BASE");

   // Once a round has been taken, the early counter is frozen.
   assert property (@(posedge clock) disable iff (reset)
      grabbed_ff && $past(grabbed_ff) |-> $stable(early_ff))
      else $error("early submission count moved after first grab");

   // A blended quotient never exceeds the cap, so the second pass cannot saturate.
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_start) && $past(cmd.blend_pass) |-> !sat_ff)
      else $error("blend division saturated");

endmodule

`default_nettype wire

// ===== sv/adaptive_sampling_rate_adjuster.sv =====
// Adaptive sampling-range adjuster, top level: asra_ctrl plus asra_datapath.
// A submit item, or a round whose count did not grow, goes from transfer
// through evaluate straight to commit; a round that rescales also runs the
// multiply and the 35-step restoring divider (used twice for a blend).
// Throughput: one item at a time; the next transfer is taken once the result
// is in the output register. Synchronous reset restores the power-on state.
`default_nettype none

module adaptive_sampling_rate_adjuster (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [asra_pkg::EXPECTED_W-1:0]      csr_write_data,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_operation,
   input  wire logic [asra_pkg::COUNT_W-1:0]         req_round_count,
   input  wire logic signed [asra_pkg::IV_W-1:0]     req_interval_us,
   input  wire logic [asra_pkg::TIME_W-1:0]          req_now_us,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [asra_pkg::RANGE_W-1:0]              rsp_sampling_range,
   output logic                                      rsp_wake_request,
   output logic                                      rsp_range_changed
);

   // The controller steps through load, evaluate, a three-chunk multiply of
   // expected rate times scale times interval, the divide by one million
   // times the count growth, an optional blend pass and the commit. The
   // datapath holds all sampler state and the output register, so a finished
   // result can wait there while the next item is already being taken.
   asra_pkg::asra_cmd_type    cmd;
   asra_pkg::asra_status_type status;

   asra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   asra_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_operation      (req_operation),
      .req_round_count    (req_round_count),
      .req_interval_us    (req_interval_us),
      .req_now_us         (req_now_us),
      .cmd                (cmd),
      .status             (status),
      .rsp_sampling_range (rsp_sampling_range),
      .rsp_wake_request   (rsp_wake_request),
      .rsp_range_changed  (rsp_range_changed)
   );

   // Once an item has been transferred in, the block holds off the next one.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer accepted while busy");

   // Every delivered range lies in 1..BASE.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sampling_range != '0) &&
                    (rsp_sampling_range <= asra_pkg::RANGE_W'(asra_pkg::BASE)))
      else $error("delivered range outside 1..BASE");

   // A result never carries both a wake request and a range change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_wake_request && rsp_range_changed))
      else $error("wake request and range change in one result");

endmodule

`default_nettype wire
